/* rtl/ray_box_slab_intersection_core_macros.svh */
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_core_macros
// Assertion helpers shared by the RTL. Each use expands to one labeled
// concurrent assertion clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECTION_CORE_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECTION_CORE_MACROS_SVH

// same-cycle implication
`define RBSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBSI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rbsi_pkg.sv */
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and helpers for the ray / box slab intersection core.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int COORD_BITS_DEF = 32;

    // ray parameter kind: finite rational, or unbounded either way
    typedef enum logic [1:0] {
        TINF_FIN = 2'd0,
        TINF_NEG = 2'd1,
        TINF_POS = 2'd2
    } tinf_t;

    // a > b for ray parameters; gt/lt compare |a.num|*b.den with |b.num|*a.den
    function automatic logic tgt(input tinf_t ai, input logic an,
                                 input tinf_t bi, input logic bn,
                                 input logic gt, input logic lt);
        logic res;
        if (ai == bi && ai != TINF_FIN) begin
            res = 1'b0;
        end else if (ai == TINF_POS || bi == TINF_NEG) begin
            res = 1'b1;
        end else if (ai == TINF_NEG || bi == TINF_POS) begin
            res = 1'b0;
        end else if (an != bn) begin
            res = bn;
        end else if (!an) begin
            res = gt;
        end else begin
            res = lt;
        end
        return res;
    endfunction

endpackage

/* rtl/ray_box_slab_intersection_core.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_core
// Ray versus axis-aligned box slab test with exact rational interval compare
// and a rounded, saturated hit point.
//
//  channel | dir | tdata (low bit up)                               | tuser
//  s_axis  | in  | origin_x/y/z, dir_x/y/z, box_min_x/y/z, max_x/y/z | -
//  m_axis  | out | point_x, point_y, point_z                        | hit
//
// One item per cycle while the skid is empty. The hit point comes from the
// bit-per-stage divider that scales the direction by the hit parameter.
// aresetn clears valid bits only.
// A two-entry output (register plus skid) lets the pipeline keep taking items
// while one result waits; the pipeline stalls as a whole once the skid is full.
// ----------------------------------------------------------------------------
`include "ray_box_slab_intersection_core_macros.svh"

module ray_box_slab_intersection_core
    import rbsi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // point_x, point_y, point_z
    output logic [((3*COORD_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // hit
    output logic [0:0] m_axis_tuser
);

    localparam int C       = COORD_BITS;
    localparam int P       = 2 * C;
    localparam int DIV_LAT = P + 1;
    localparam int SL      = 8 + DIV_LAT;
    localparam int OUT_W   = ((3*C+7)/8)*8;
    localparam int VW      = P + 3;

    typedef struct packed {
        tinf_t        inf;
        logic [C:0]   num;   // two's complement
        logic [C-1:0] den;
    } tpar_t;

    typedef struct packed {
        logic [2:0][C-1:0] o;
        logic [2:0][C-1:0] dmag;
        logic [2:0]        dneg;
        logic [2:0]        dz;
    } side_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] do_div;
    } flag_t;

    function automatic logic [C-1:0] mag_n(input logic [C:0] v);
        logic [C:0] a;
        a = v[C] ? (~v + 1'b1) : v;
        return a[C-1:0];
    endfunction

    function automatic logic [P-1:0] umul(input logic [C-1:0] a, input logic [C-1:0] b);
        return {{C{1'b0}}, a} * {{C{1'b0}}, b};
    endfunction

    function automatic logic tcmp(input tpar_t a, input tpar_t b,
                                  input logic [P-1:0] pa, input logic [P-1:0] pb);
        return tgt(a.inf, a.num[C], b.inf, b.num[C], pa > pb, pa < pb);
    endfunction

    logic en;
    logic skid_valid_reg;
    logic m_valid_reg;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    logic  vld_reg  [0:SL-1];
    side_t side_reg [0:SL-1];

    // ---------------- stage 1: slabs per axis ----------------
    tpar_t en1_next [3];
    tpar_t ex1_next [3];
    side_t side1;
    logic  miss1_next;

    always_comb begin
        logic signed [C-1:0] o, d, lo, hi;
        logic signed [C:0]   oe, loe, hie, de, dm;
        miss1_next = 1'b0;
        side1      = '0;
        for (int k = 0; k < 3; k++) begin
            o   = s_axis_tdata[k*C +: C];
            d   = s_axis_tdata[(3+k)*C +: C];
            lo  = s_axis_tdata[(6+k)*C +: C];
            hi  = s_axis_tdata[(9+k)*C +: C];
            oe  = {o[C-1], o};
            loe = {lo[C-1], lo};
            hie = {hi[C-1], hi};
            de  = {d[C-1], d};
            dm  = d[C-1] ? -de : de;
            side1.o[k]    = o;
            side1.dmag[k] = dm[C-1:0];
            side1.dneg[k] = d[C-1];
            side1.dz[k]   = (d == '0);
            if (d == '0) begin
                en1_next[k] = '{inf: TINF_NEG, num: '0, den: C'(1)};
                ex1_next[k] = '{inf: TINF_POS, num: '0, den: C'(1)};
                if (o < lo || o > hi) begin
                    miss1_next = 1'b1;
                end
            end else if (d[C-1]) begin
                en1_next[k] = '{inf: TINF_FIN, num: oe - hie, den: dm[C-1:0]};
                ex1_next[k] = '{inf: TINF_FIN, num: oe - loe, den: dm[C-1:0]};
            end else begin
                en1_next[k] = '{inf: TINF_FIN, num: loe - oe, den: dm[C-1:0]};
                ex1_next[k] = '{inf: TINF_FIN, num: hie - oe, den: dm[C-1:0]};
            end
        end
    end

    tpar_t en1_reg [3];
    tpar_t ex1_reg [3];
    logic  miss1_reg;

    // ---------------- stage 2: x/y cross products ----------------
    tpar_t en2_reg [3];
    tpar_t ex2_reg [3];
    logic  miss2_reg;
    logic [P-1:0] pxn2_reg, pxx2_reg, pyn2_reg, pyx2_reg;

    // ---------------- stage 3: merge x with y ----------------
    tpar_t tmin3_next, tmax3_next;
    logic  miss3_next;

    always_comb begin
        logic c1, c2, c3, c4;
        c1 = tcmp(en2_reg[0], ex2_reg[1], pxn2_reg, pyx2_reg);
        c2 = tcmp(en2_reg[1], ex2_reg[0], pyn2_reg, pxx2_reg);
        c3 = tcmp(en2_reg[1], en2_reg[0], pyn2_reg, pxn2_reg);
        c4 = tcmp(ex2_reg[0], ex2_reg[1], pxx2_reg, pyx2_reg);
        miss3_next = miss2_reg | c1 | c2;
        tmin3_next = c3 ? en2_reg[1] : en2_reg[0];
        tmax3_next = c4 ? ex2_reg[1] : ex2_reg[0];
    end

    tpar_t tmin3_reg, tmax3_reg, enz3_reg, exz3_reg;
    logic  miss3_reg;

    // ---------------- stage 4: products against z ----------------
    tpar_t tmin4_reg, tmax4_reg, enz4_reg, exz4_reg;
    logic  miss4_reg;
    logic [P-1:0] an4_reg, ax4_reg, zna4_reg, zxa4_reg, znb4_reg, zxb4_reg;

    // ---------------- stage 5: merge with z ----------------
    tpar_t tmin5_next, tmax5_next;
    logic  miss5_next;

    always_comb begin
        logic c1, c2, c3, c4;
        c1 = tcmp(tmin4_reg, exz4_reg, an4_reg, zxa4_reg);
        c2 = tcmp(enz4_reg, tmax4_reg, znb4_reg, ax4_reg);
        c3 = tcmp(enz4_reg, tmin4_reg, zna4_reg, an4_reg);
        c4 = tcmp(tmax4_reg, exz4_reg, ax4_reg, zxb4_reg);
        miss5_next = miss4_reg | c1 | c2;
        tmin5_next = c3 ? enz4_reg : tmin4_reg;
        tmax5_next = c4 ? exz4_reg : tmax4_reg;
    end

    tpar_t tmin5_reg, tmax5_reg;
    logic  miss5_reg;

    // ---------------- stage 6: tmin vs tmax products, exit behind origin ---
    tpar_t tmin6_reg, tmax6_reg;
    logic  miss6_reg;
    logic [P-1:0] pa6_reg, pb6_reg;

    // ---------------- stage 7: pick t ----------------
    tpar_t tsel7;
    always_comb begin
        tpar_t zero;
        zero = '{inf: TINF_FIN, num: '0, den: C'(1)};
        if (tmin6_reg.inf == TINF_FIN && !tmin6_reg.num[C] && (|tmin6_reg.num)) begin
            tsel7 = tcmp(tmin6_reg, tmax6_reg, pa6_reg, pb6_reg) ? tmax6_reg : tmin6_reg;
        end else begin
            tsel7 = zero;
        end
    end

    logic [C-1:0] tnum7_reg, tden7_reg;
    logic         tpos7_reg, hit7_reg;

    // ---------------- stage 8: t*|d| ----------------
    logic [P-1:0] m8_reg [3];
    logic [C-1:0] den8_reg;
    flag_t        fl_reg [0:DIV_LAT];
    flag_t        fl8_next;

    always_comb begin
        fl8_next.hit = hit7_reg;
        for (int k = 0; k < 3; k++) begin
            fl8_next.do_div[k] = tpos7_reg && !side_reg[6].dz[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            en1_reg   <= en1_next;
            ex1_reg   <= ex1_next;
            miss1_reg <= miss1_next;
            // stage 2
            en2_reg   <= en1_reg;
            ex2_reg   <= ex1_reg;
            miss2_reg <= miss1_reg;
            pxn2_reg  <= umul(mag_n(en1_reg[0].num), en1_reg[1].den);
            pxx2_reg  <= umul(mag_n(ex1_reg[0].num), en1_reg[1].den);
            pyn2_reg  <= umul(mag_n(en1_reg[1].num), en1_reg[0].den);
            pyx2_reg  <= umul(mag_n(ex1_reg[1].num), en1_reg[0].den);
            // stage 3
            tmin3_reg <= tmin3_next;
            tmax3_reg <= tmax3_next;
            enz3_reg  <= en2_reg[2];
            exz3_reg  <= ex2_reg[2];
            miss3_reg <= miss3_next;
            // stage 4
            tmin4_reg <= tmin3_reg;
            tmax4_reg <= tmax3_reg;
            enz4_reg  <= enz3_reg;
            exz4_reg  <= exz3_reg;
            miss4_reg <= miss3_reg;
            an4_reg   <= umul(mag_n(tmin3_reg.num), enz3_reg.den);
            ax4_reg   <= umul(mag_n(tmax3_reg.num), enz3_reg.den);
            zna4_reg  <= umul(mag_n(enz3_reg.num), tmin3_reg.den);
            zxa4_reg  <= umul(mag_n(exz3_reg.num), tmin3_reg.den);
            znb4_reg  <= umul(mag_n(enz3_reg.num), tmax3_reg.den);
            zxb4_reg  <= umul(mag_n(exz3_reg.num), tmax3_reg.den);
            // stage 5
            tmin5_reg <= tmin5_next;
            tmax5_reg <= tmax5_next;
            miss5_reg <= miss5_next;
            // stage 6: a finite exit below zero means the box lies behind
            tmin6_reg <= tmin5_reg;
            tmax6_reg <= tmax5_reg;
            miss6_reg <= miss5_reg | (tmax5_reg.inf == TINF_FIN && tmax5_reg.num[C]);
            pa6_reg   <= umul(mag_n(tmin5_reg.num), tmax5_reg.den);
            pb6_reg   <= umul(mag_n(tmax5_reg.num), tmin5_reg.den);
            // stage 7
            tnum7_reg <= mag_n(tsel7.num);
            tden7_reg <= tsel7.den;
            tpos7_reg <= !tsel7.num[C] && (|tsel7.num);
            hit7_reg  <= !miss6_reg;
            // stage 8
            for (int k = 0; k < 3; k++) begin
                m8_reg[k] <= umul(tnum7_reg, side_reg[6].dmag[k]);
            end
            den8_reg  <= tden7_reg;
            fl_reg[0] <= fl8_next;
            for (int i = 1; i <= DIV_LAT; i++) begin
                fl_reg[i] <= fl_reg[i-1];
            end
            // side line
            side_reg[0] <= side1;
            for (int i = 1; i < SL; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SL; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < SL; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- divide t*|d| by den, per axis ----------------
    logic [P:0] q [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        rbsi_rdiv #(
            .NUM_BITS (P),
            .DEN_BITS (C)
        ) u_div (
            .aclk     (aclk),
            .en       (en),
            .dividend (m8_reg[k]),
            .divisor  (den8_reg),
            .quot     (q[k])
        );
    end

    // ---------------- add to origin and saturate ----------------
    logic [3*C-1:0] pt_fin;
    logic           hit_fin;

    always_comb begin
        logic signed [VW-1:0] ow, qw, vw;
        side_t sd;
        flag_t fl;
        sd      = side_reg[SL-1];
        fl      = fl_reg[DIV_LAT];
        hit_fin = fl.hit;
        pt_fin  = '0;
        for (int k = 0; k < 3; k++) begin
            ow = {{(VW-C){sd.o[k][C-1]}}, sd.o[k]};
            qw = {2'b00, q[k]};
            if (fl.do_div[k]) begin
                vw = sd.dneg[k] ? ow - qw : ow + qw;
            end else begin
                vw = ow;
            end
            if (!fl.hit) begin
                pt_fin[k*C +: C] = '0;
            end else if (&vw[VW-1:C-1] || !(|vw[VW-1:C-1])) begin
                pt_fin[k*C +: C] = vw[C-1:0];
            end else if (vw[VW-1]) begin
                pt_fin[k*C +: C] = {1'b1, {(C-1){1'b0}}};
            end else begin
                pt_fin[k*C +: C] = {1'b0, {(C-1){1'b1}}};
            end
        end
    end

    // ---------------- output register and skid ----------------
    logic [3*C-1:0] out_pt_reg, skid_pt_reg;
    logic           out_hit_reg, skid_hit_reg;
    logic           out_free;

    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg    <= skid_valid_reg || vld_reg[SL-1];
            skid_valid_reg <= 1'b0;
        end else if (en && vld_reg[SL-1]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_pt_reg  <= skid_valid_reg ? skid_pt_reg : pt_fin;
            out_hit_reg <= skid_valid_reg ? skid_hit_reg : hit_fin;
        end else if (en) begin
            skid_pt_reg  <= pt_fin;
            skid_hit_reg <= hit_fin;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = {{(OUT_W-3*C){1'b0}}, out_pt_reg};
    assign m_axis_tuser[0] = out_hit_reg;

    `RBSI_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_valid_reg,
        "skid holds a result while the output register is empty")
    `RBSI_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0,
        "miss result carries a nonzero point")
    `RBSI_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_reg[0],
        "accepted transfer did not enter the pipeline")
    `RBSI_ASSERT_NOW(a_skid_cause, $rose(skid_valid_reg),
        $past(m_axis_tvalid && !m_axis_tready),
        "skid filled without an output stall")

endmodule

/* rtl/rbsi_rdiv.sv */
// ----------------------------------------------------------------------------
// rbsi_rdiv
// Pipelined restoring divider, one quotient bit per stage, with a final
// round-to-nearest (ties up) stage. Stages advance only while en is high.
// ----------------------------------------------------------------------------
module rbsi_rdiv
    import rbsi_pkg::*;
#(
    parameter int NUM_BITS = 2 * COORD_BITS_DEF,
    parameter int DEN_BITS = COORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic [NUM_BITS:0]   quot
);

    logic [DEN_BITS-1:0] rem_reg [1:NUM_BITS];
    logic [NUM_BITS-1:0] sh_reg  [1:NUM_BITS];
    logic [DEN_BITS-1:0] dv_reg  [1:NUM_BITS];
    logic [NUM_BITS:0]   quot_reg;

    for (genvar k = 1; k <= NUM_BITS; k++) begin : g_stage
        logic [DEN_BITS-1:0] pr_rem;
        logic [NUM_BITS-1:0] pr_sh;
        logic [DEN_BITS-1:0] pr_dv;
        logic [DEN_BITS:0]   part;
        logic [DEN_BITS:0]   diff;
        logic                ge;

        if (k == 1) begin : g_first
            assign pr_rem = '0;
            assign pr_sh  = dividend;
            assign pr_dv  = divisor;
        end else begin : g_rest
            assign pr_rem = rem_reg[k-1];
            assign pr_sh  = sh_reg[k-1];
            assign pr_dv  = dv_reg[k-1];
        end

        assign part = {pr_rem, pr_sh[NUM_BITS-1]};
        assign ge   = part >= {1'b0, pr_dv};
        assign diff = part - {1'b0, pr_dv};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DEN_BITS-1:0] : part[DEN_BITS-1:0];
                sh_reg[k]  <= {pr_sh[NUM_BITS-2:0], ge};
                dv_reg[k]  <= pr_dv;
            end
        end
    end

    logic rnd;
    assign rnd = {rem_reg[NUM_BITS], 1'b0} >= {1'b0, dv_reg[NUM_BITS]};

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= {1'b0, sh_reg[NUM_BITS]} + {{NUM_BITS{1'b0}}, rnd};
        end
    end

    assign quot = quot_reg;

endmodule

/* tb/ray_box_slab_intersection_checker.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_checker
// Watches both stream channels of the ray / box core, predicts each hit
// result from the accepted input transfer, and compares results in order.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_checker
    import rbsi_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [383:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    output int           fail_count,
    output int           pending_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              hit;
        logic signed [31:0] pt[3];
    } hit_result_t;

    // ray parameter: exact rational num/den or unbounded
    typedef struct {
        tinf_t              kind;
        logic signed [63:0] num;
        logic [63:0]        den;
    } ray_param_t;

    hit_result_t expected_hits[$];

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // a > b
    function automatic logic param_greater(input ray_param_t a, input ray_param_t b);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic         an;
        logic         bn;
        if (a.kind == b.kind && a.kind != TINF_FIN) return 1'b0;
        if (a.kind == TINF_POS || b.kind == TINF_NEG) return 1'b1;
        if (a.kind == TINF_NEG || b.kind == TINF_POS) return 1'b0;
        an = a.num < 0;
        bn = b.num < 0;
        if (an != bn) return bn;
        lhs = {64'd0, magnitude(a.num)} * {64'd0, b.den};
        rhs = {64'd0, magnitude(b.num)} * {64'd0, a.den};
        return an ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic logic slab_interval(input logic signed [63:0] o,
                                           input logic signed [63:0] d,
                                           input logic signed [63:0] lo,
                                           input logic signed [63:0] hi,
                                           output ray_param_t entry,
                                           output ray_param_t leave);
        entry = '{TINF_FIN, 64'sd0, 64'd1};
        leave = '{TINF_FIN, 64'sd0, 64'd1};
        if (d == 0) begin
            if (o < lo || o > hi) return 1'b0;
            entry.kind = TINF_NEG;
            leave.kind = TINF_POS;
        end else if (d > 0) begin
            entry = '{TINF_FIN, lo - o, d};
            leave = '{TINF_FIN, hi - o, d};
        end else begin
            entry = '{TINF_FIN, o - hi, magnitude(d)};
            leave = '{TINF_FIN, o - lo, magnitude(d)};
        end
        return 1'b1;
    endfunction

    function automatic hit_result_t predict_hit(input logic [383:0] v);
        hit_result_t        res;
        logic signed [63:0] o[3];
        logic signed [63:0] d[3];
        logic signed [63:0] bl[3];
        logic signed [63:0] bh[3];
        logic signed [63:0] p;
        ray_param_t         tmin, tmax, an, ax, zero, t;
        logic [127:0]       prod, q, r;
        res.hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            res.pt[k] = '0;
            o[k]  = 64'($signed(v[32*k +: 32]));
            d[k]  = 64'($signed(v[32*(3+k) +: 32]));
            bl[k] = 64'($signed(v[32*(6+k) +: 32]));
            bh[k] = 64'($signed(v[32*(9+k) +: 32]));
        end
        if (!slab_interval(o[0], d[0], bl[0], bh[0], tmin, tmax)) return res;
        for (int k = 1; k < 3; k++) begin
            if (!slab_interval(o[k], d[k], bl[k], bh[k], an, ax)) return res;
            if (param_greater(tmin, ax) || param_greater(an, tmax)) return res;
            if (param_greater(an, tmin)) tmin = an;
            if (param_greater(tmax, ax)) tmax = ax;
        end
        zero = '{TINF_FIN, 64'sd0, 64'd1};
        if (param_greater(zero, tmax)) return res;
        t = param_greater(tmin, zero) ? tmin : zero;
        if (param_greater(t, tmax)) t = tmax;
        res.hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            p = o[k];
            if (d[k] != 0 && t.num > 0) begin
                prod = {64'd0, magnitude(t.num)} * {64'd0, magnitude(d[k])};
                q = prod / {64'd0, t.den};
                r = prod % {64'd0, t.den};
                // round half away from zero
                if (r >= {64'd0, t.den} - r) q = q + 128'd1;
                if (q > (128'd1 << 62)) q = 128'd1 << 62;
                p = d[k] < 0 ? p - $signed(q[63:0]) : p + $signed(q[63:0]);
            end
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            res.pt[k] = p[31:0];
        end
        return res;
    endfunction

    assign pending_hits = expected_hits.size();

    always @(posedge aclk) begin
        hit_result_t exp_r;
        logic        bad;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) expected_hits.push_back(predict_hit(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_hits.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result transfer hit=%0d data=%h",
                                 m_axis_tuser, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_hits.pop_front();
                    bad = exp_r.hit != m_axis_tuser[0];
                    for (int k = 0; k < 3; k++)
                        if (exp_r.pt[k] != m_axis_tdata[32*k +: 32]) bad = 1'b1;
                    if (bad) begin
                        if (fail_count < 10)
                            $display("ERROR: expected hit=%0d pt=%h %h %h, got hit=%0d pt=%h %h %h",
                                     exp_r.hit, exp_r.pt[0], exp_r.pt[1], exp_r.pt[2],
                                     m_axis_tuser[0], m_axis_tdata[31:0],
                                     m_axis_tdata[63:32], m_axis_tdata[95:64]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/ray_box_slab_intersection_core_test.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_core_test
// Drives directed and random ray / box pairs into the slab intersection core
// with random idle bursts on both channels; the checker scores every result.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_RAYS = 900;
    localparam int CALM_RAYS   = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 100;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    int           fail_count;
    int           pending_hits;
    int           cycles = 0;
    logic         calm = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    ray_box_slab_intersection_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    ray_box_slab_intersection_checker i_checker (.*);

    function automatic logic [383:0] ray_box(input int ox, oy, oz, dx, dy, dz,
                                             input int ax, ay, az, bx, by, bz);
        return {bz, by, bx, az, ay, ax, dz, dy, dx, oz, oy, ox};
    endfunction

    // mostly aimed rays at small boxes, plus extremes and raw noise
    function automatic logic [383:0] random_ray_box();
        int lo[3], hi[3], o[3], d[3];
        int mode;
        logic [383:0] v;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            for (int k = 0; k < 12; k++) v[32*k +: 32] = $urandom;
            return v;
        end
        for (int k = 0; k < 3; k++) begin
            lo[k] = $signed($urandom_range(0, 2**21)) - 2**20;
            hi[k] = lo[k] + $urandom_range(0, 2**18);
            if ($urandom_range(0, 15) == 0) hi[k] = lo[k] - $urandom_range(1, 100);
            o[k] = $signed($urandom_range(0, 2**23)) - 2**22;
            if ($urandom_range(0, 7) == 0) o[k] = lo[k] + $urandom_range(0, hi[k] - lo[k]);
            d[k] = (lo[k] / 2 + hi[k] / 2 - o[k]) + $signed($urandom_range(0, 4096)) - 2048;
            if ($urandom_range(0, 9) == 0) d[k] = 0;
            if ($urandom_range(0, 9) == 0) d[k] = -d[k];
            if (mode == 1) begin
                o[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
                d[k] = $urandom;
                lo[k] = $urandom_range(0, 1) ? 32'h8000_0000 : lo[k];
                hi[k] = $urandom_range(0, 1) ? 32'h7fff_ffff : hi[k];
            end
        end
        return ray_box(o[0], o[1], o[2], d[0], d[1], d[2],
                       lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic send_ray(input logic [383:0] v);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    // receiver stalls in bursts
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_axis_tready = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 2);
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // hit from outside, positive and negative directions
        send_ray(ray_box(-5 << 16, 0, 0, 1 << 16, 0, 0,
                         -1 << 16, -1 << 16, -1 << 16, 1 << 16, 1 << 16, 1 << 16));
        send_ray(ray_box(5 << 16, 3 << 15, -7 << 14, -2 << 16, -1 << 14, 1 << 14,
                         -1 << 16, -1 << 16, -1 << 16, 1 << 16, 1 << 16, 1 << 16));
        // box behind origin: miss
        send_ray(ray_box(5 << 16, 0, 0, 1 << 16, 0, 0,
                         -1 << 16, -1 << 16, -1 << 16, 1 << 16, 1 << 16, 1 << 16));
        // origin inside box: point is origin
        send_ray(ray_box(100, -200, 300, 7, -9, 11,
                         -1 << 16, -1 << 16, -1 << 16, 1 << 16, 1 << 16, 1 << 16));
        // zero direction on boundary, and just outside
        send_ray(ray_box(-5 << 16, 1 << 16, 0, 1 << 16, 0, 0,
                         -1 << 16, -1 << 16, -1 << 16, 1 << 16, 1 << 16, 1 << 16));
        send_ray(ray_box(-5 << 16, (1 << 16) + 1, 0, 1 << 16, 0, 0,
                         -1 << 16, -1 << 16, -1 << 16, 1 << 16, 1 << 16, 1 << 16));
        // all-zero direction inside and outside
        send_ray(ray_box(5, 6, 7, 0, 0, 0, 0, 0, 0, 10, 10, 10));
        send_ray(ray_box(11, 6, 7, 0, 0, 0, 0, 0, 0, 10, 10, 10));
        // inverted box
        send_ray(ray_box(0, 0, 0, 1, 1, 1, 10, 10, 10, 5, 5, 5));
        send_ray(ray_box(20, 0, 0, -1, 0, 0, 10, -1, -1, 5, 1, 1));
        // huge products, saturation
        send_ray(ray_box(32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                         32'h7fff_fffe, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_ray(ray_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, -1,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff));
        send_ray(ray_box(0, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000,
                         32'h7fff_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        // ties in rounding: t = 1/2
        send_ray(ray_box(0, 0, 0, 2, 3, -5, 1, -10, -10, 10, 10, 10));
        send_ray(ray_box(0, 0, 0, 2, -3, 5, 1, -10, -10, 10, 10, 10));
        // grazing an edge, and disjoint slabs
        send_ray(ray_box(0, 0, 0, 4, 4, 0, 4, 4, -1, 8, 8, 1));
        send_ray(ray_box(0, 0, 0, 4, 1, 0, 4, 4, -1, 8, 8, 1));
        send_ray(ray_box(-1, -1, -1, -1, -1, -1, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_ray(ray_box(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        // hold off until every result is back
        while (pending_hits != 0) @(negedge aclk);
        for (int i = 0; i < RANDOM_RAYS; i++) begin
            if (i == RANDOM_RAYS - CALM_RAYS) calm = 1'b1;
            send_ray(random_ray_box());
        end
        while (pending_hits != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/rbsi_pkg.sv
rtl/rbsi_rdiv.sv
rtl/ray_box_slab_intersection_core.sv
tb/ray_box_slab_intersection_checker.sv
tb/ray_box_slab_intersection_core_test.sv
